// File: sv/fpba_pkg.sv
`default_nettype none

package fpba_pkg;

  // Default sizing of the block table.
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Item commands.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Placement policies.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration register map.
  localparam int           CFG_IDX_W       = 1;
  localparam int           CFG_DATA_W      = 5;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;
  localparam logic [1:0]   FIT_MODE_RST    = FIT_FIRST;
  localparam logic [4:0]   BLOCK_COUNT_RST = 5'd16;

  // Field widths of the items.
  localparam int LOAD_IDX_W  = 4;
  localparam int SIZE_VAL_W  = 16;
  localparam int CHOSEN_W    = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

endpackage : fpba_pkg

`default_nettype wire

// File: sv/fit_policy_block_allocator_top.sv
`default_nettype none

// Channel   Dir  Payload                                           Handshake
// in_       in   tdata: command, load_index, size_value; tlast     tvalid/tready
// out_      out  tdata: granted, chosen_block; tlast = batch_done  tvalid/tready
// cfg_      in   cfg_index, cfg_wdata (fit_mode, block_count)      cfg_we
//
// A load item is written into the block table in the cycle it is accepted.
// A request item is served before the next item can be taken: one
// comparator walks the table one entry per cycle behind the registered read
// port of the table, up to min(block_count, NUM_BLOCKS) entries, and a final
// update state charges the block once the output register is free.
// A finished result waits in the output register, so a stalled out_ side only
// holds the block once a second request is ready to deliver its result.
// Reset (rst_n, synchronous, active low) clears control and configuration;
// the table itself is not cleared and must be loaded before it is scanned.
module fit_policy_block_allocator_top
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [0] command, [4:1] load_index, [20:5] size_value, [23:21] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tlast,      // last_request

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] granted, [4:1] chosen_block, [7:5] zero
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,     // batch_done

  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Table address width, scan counter width (holds NUM_BLOCKS itself), and
  // the common widths used to compare the narrow fields against the depth.
  localparam int AW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int LDX_W  = (CNT_W > LOAD_IDX_W) ? CNT_W : LOAD_IDX_W;
  localparam int PICK_W = (AW > CHOSEN_W) ? AW : CHOSEN_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  // Input item fields.
  logic                  in_cmd;
  logic [LOAD_IDX_W-1:0] in_load_index;
  logic [SIZE_VAL_W-1:0] in_size_value;
  logic                  in_acc;

  assign in_cmd        = in_tdata[0];
  assign in_load_index = in_tdata[4:1];
  assign in_size_value = in_tdata[20:5];
  assign in_acc        = in_tvalid && in_tready;

  // Configuration registers.
  logic [1:0] fit_mode_r;
  logic [4:0] block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= FIT_MODE_RST;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE:    fit_mode_r    <= cfg_wdata[1:0];
        REG_BLOCK_COUNT: block_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer and scan registers.
  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     lim_r, lim_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 dv_r, dv_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 last_r, last_nxt;

  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_granted_r, out_granted_nxt;
  logic [CHOSEN_W-1:0]  out_chosen_r, out_chosen_nxt;
  logic                 out_last_r, out_last_nxt;

  // Table ports.
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] rd_data;

  // Load address check and the clamped scan limit.
  logic [LDX_W-1:0]     ld_ext;
  logic                 ld_ok;
  logic [LIM_W-1:0]     bc_ext;
  logic [LIM_W-1:0]     lim_full;
  logic [SIZE_BITS-1:0] in_size;

  assign ld_ext   = LDX_W'(in_load_index);
  assign ld_ok    = ld_ext < LDX_W'(NUM_BLOCKS);
  assign bc_ext   = LIM_W'(block_count_r);
  assign lim_full = (bc_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : bc_ext;
  assign in_size  = SIZE_BITS'(in_size_value);

  // The shared compare unit: does the entry fit, and does it beat the
  // current candidate under the selected policy. Ties keep the lower index.
  logic fits;
  logic better;
  logic take;

  always_comb begin
    fits = size_r <= rd_data;
    case (fit_mode_r)
      FIT_BEST:  better = rd_data < best_r;
      FIT_WORST: better = rd_data > best_r;
      default:   better = 1'b0;
    endcase
    take = dv_r && fits && (!found_r || better);
  end

  logic out_free;
  logic [PICK_W-1:0] pick_ext;

  assign out_free = !out_tvalid_r || out_tready;
  assign pick_ext = PICK_W'(pick_r);

  always_comb begin
    state_nxt       = state_r;
    lim_nxt         = lim_r;
    issue_nxt       = issue_r;
    dv_nxt          = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    best_nxt        = best_r;
    size_nxt        = size_r;
    last_nxt        = last_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_granted_nxt = out_granted_r;
    out_chosen_nxt  = out_chosen_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_addr         = ld_ext[AW-1:0];
    wr_data         = in_size;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_LOAD) begin
            wr_en = ld_ok;
          end else begin
            lim_nxt   = lim_full[CNT_W-1:0];
            issue_nxt = '0;
            found_nxt = 1'b0;
            pick_nxt  = '0;
            size_nxt  = in_size;
            last_nxt  = in_tlast;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous entry is compared.
        if (issue_r != lim_r) begin
          dv_nxt      = 1'b1;
          cmp_idx_nxt = issue_r[AW-1:0];
          issue_nxt   = issue_r + 1'b1;
        end else begin
          // The entry compared in this cycle is the last one.
          state_nxt = S_UPD;
        end
        if (take) begin
          found_nxt = 1'b1;
          pick_nxt  = cmp_idx_r;
          best_nxt  = rd_data;
        end
      end

      S_UPD: begin
        if (out_free) begin
          wr_en           = found_r;
          wr_addr         = pick_r;
          wr_data         = best_r - size_r;
          out_tvalid_nxt  = 1'b1;
          out_granted_nxt = found_r;
          out_chosen_nxt  = found_r ? pick_ext[CHOSEN_W-1:0] : '0;
          out_last_nxt    = last_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dv_r         <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dv_r         <= dv_nxt;
      found_r      <= found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r         <= lim_nxt;
    issue_r       <= issue_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    pick_r        <= pick_nxt;
    best_r        <= best_nxt;
    size_r        <= size_nxt;
    last_r        <= last_nxt;
    out_granted_r <= out_granted_nxt;
    out_chosen_r  <= out_chosen_nxt;
    out_last_r    <= out_last_nxt;
  end

  fpba_store #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CHOSEN_W - 1){1'b0}}, out_chosen_r, out_granted_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // A request occupies the block: no item is taken in the next cycle.
  a_req_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_REQUEST) |=> !in_tready)
    else $error("input accepted right after a request");

  // Read data is only marked valid while the table is being walked.
  a_dv_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == S_SCAN))
    else $error("compare data valid outside the scan");

  // The read counter never runs past the scan limit.
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (issue_r <= lim_r))
    else $error("scan counter past the limit");

  // A charged block always lies inside the scanned range.
  a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && found_r) |-> (CNT_W'(pick_r) < lim_r))
    else $error("chosen block outside the scanned range");
`endif

endmodule : fit_policy_block_allocator_top

`default_nettype wire

// File: sv/fpba_store.sv
`default_nettype none

// Table of remaining block sizes: one write port, one read port with a
// registered read.
module fpba_store
  import fpba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  localparam int AW        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [SIZE_BITS-1:0] wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [SIZE_BITS-1:0] rd_data
);

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : fpba_store

`default_nettype wire

// File: tb/sv/alloc_checker.sv
module alloc_checker
  import fpba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // [0] command, [4:1] load_index, [20:5] size_value, [23:21] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,      // last_request
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] granted, [4:1] chosen_block, [7:5] zero
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,     // batch_done
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     open_requests,
  output int                     results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                granted;
    logic [CHOSEN_W-1:0] chosen;
    logic                done;
  } grant_t;

  logic [SIZE_VAL_W-1:0] free_size [NUM_BLOCKS_DEF];
  logic [1:0]            policy;
  logic [4:0]            scan_count;
  grant_t                grant_q [$];

  initial begin
    mismatches   = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Scans the table under the current policy and charges the chosen block.
  function automatic grant_t charge_block(input logic [SIZE_VAL_W-1:0] want,
                                          input logic last);
    int     limit;
    int     pick;
    bit     found;
    grant_t r;
    limit = (scan_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(scan_count);
    pick  = 0;
    found = 1'b0;
    for (int j = 0; j < limit; j++) begin
      if (want <= free_size[j]) begin
        if (!found) begin
          pick  = j;
          found = 1'b1;
          if (policy != FIT_BEST && policy != FIT_WORST) break;
        end else if (policy == FIT_BEST && free_size[j] < free_size[pick]) begin
          pick = j;
        end else if (policy == FIT_WORST && free_size[j] > free_size[pick]) begin
          pick = j;
        end
      end
    end
    r.granted = found;
    r.chosen  = found ? pick[CHOSEN_W-1:0] : '0;
    r.done    = last;
    if (found) free_size[pick] = free_size[pick] - want;
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t exp_r;
    if (!rst_n) begin
      policy     = FIT_MODE_RST;
      scan_count = BLOCK_COUNT_RST;
      grant_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (grant_q.size() == 0) begin
          report_mismatch("result with no request waiting, tdata", out_tdata, 0);
        end else begin
          exp_r = grant_q.pop_front();
          if (out_tdata[0] !== exp_r.granted)
            report_mismatch("granted", out_tdata[0], exp_r.granted);
          if (out_tdata[4:1] !== exp_r.chosen)
            report_mismatch("chosen_block", out_tdata[4:1], exp_r.chosen);
          if (out_tlast !== exp_r.done)
            report_mismatch("batch_done", out_tlast, exp_r.done);
          if (out_tdata[OUT_TDATA_W-1:5] !== '0)
            report_mismatch("tdata padding", out_tdata[OUT_TDATA_W-1:5], 0);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tdata[0] == CMD_REQUEST)
          grant_q.push_back(charge_block(in_tdata[20:5], in_tlast));
        else
          free_size[in_tdata[4:1]] = in_tdata[20:5];
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FIT_MODE:    policy     = cfg_wdata[1:0];
          REG_BLOCK_COUNT: scan_count = cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
    open_requests <= grant_q.size();
  end

endmodule : alloc_checker

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpba_pkg::*;

  // The unused fourth policy code, which the block treats as first fit.
  localparam logic [1:0] FIT_SPARE = 2'd3;

  localparam int NUM_PHASES       = 14;
  localparam int ITEMS_PER_PHASE  = 95;
  // The margin covers the longest request scan and the output register.
  localparam int SETTLE_CYCLES    = NUM_BLOCKS_DEF + 8;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [0] command, [4:1] load_index, [20:5] size_value, [23:21] zero
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;   // last_request
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] granted, [4:1] chosen_block, [7:5] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;           // batch_done
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int mismatches;
  int open_requests;
  int results_seen;
  int items_sent    = 0;
  int requests_sent = 0;

  // Once set, random sender gaps and result stalls stop; the last phases run at full rate.
  bit calm = 1'b0;

  always #5 clk = ~clk;

  fit_policy_block_allocator_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // The checker watches every channel, keeps its own copy of the block table
  // and the registers, and compares each result with the oldest prediction.
  alloc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .open_requests (open_requests),
    .results_seen  (results_seen)
  );

  // Presents one item and returns at the edge where it is accepted. The valid
  // stays high afterwards, so back-to-back items need no extra assignment.
  task automatic send_item(input logic cmd, input logic [LOAD_IDX_W-1:0] idx,
                           input logic [SIZE_VAL_W-1:0] size, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, size, idx, cmd};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_REQUEST) requests_sent++;
  endtask

  // Random sender gap of random length after about one item in five.
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stops sending, waits for every predicted result to come back, then lets
  // the block finish whatever it may still be doing. The first edge makes
  // sure the checker has seen the last accepted item.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_requests != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the fit mode, then the block count, on consecutive edges; only called while idle.
  task automatic set_policy(input logic [1:0] mode, input logic [4:0] count);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIT_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_BLOCK_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: ready runs of random length, some long, broken by random stalls
  // until the run turns calm.
  initial begin : result_sink
    int run;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      run = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      if (!calm) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic                  cmd;
    logic [LOAD_IDX_W-1:0] idx;
    logic [SIZE_VAL_W-1:0] size;
    logic                  last;
    logic [1:0]            mode;
    logic [4:0]            count;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Every block is loaded before anything is scanned, since
    // the table holds no defined value after reset. Blocks 3 and 4 tie at
    // 200 and blocks 5 and 6 at 500, so ties under best and worst fit must
    // go to the lower index. Block 1 holds the full-width size and block 2
    // holds zero. Loads carry a toggling tlast that the block must ignore.
    set_policy(FIT_FIRST, BLOCK_COUNT_RST);
    for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
      case (i)
        0:       size = 16'd300;
        1:       size = 16'hFFFF;
        2:       size = 16'd0;
        3, 4:    size = 16'd200;
        5, 6:    size = 16'd500;
        default: size = 16'd100;
      endcase
      send_item(CMD_LOAD, LOAD_IDX_W'(i), size, i[0]);
      maybe_gap();
    end
    // First fit: a zero request fits the first block and charges nothing,
    // a full-width request only fits block 1 and then misses, and 250 lands
    // in block 0 again.
    send_item(CMD_REQUEST, 4'hF, 16'd0, 1'b0);
    send_item(CMD_REQUEST, 4'h0, 16'hFFFF, 1'b1);
    send_item(CMD_REQUEST, 4'hA, 16'hFFFF, 1'b0);
    send_item(CMD_REQUEST, 4'h5, 16'd250, 1'b1);
    settle();
    set_policy(FIT_BEST, BLOCK_COUNT_RST);
    send_item(CMD_REQUEST, 4'h3, 16'd150, 1'b0);
    send_item(CMD_REQUEST, 4'hC, 16'hFFFF, 1'b1);
    settle();
    set_policy(FIT_WORST, BLOCK_COUNT_RST);
    send_item(CMD_REQUEST, 4'h6, 16'd10, 1'b0);
    send_item(CMD_REQUEST, 4'h9, 16'hFFFF, 1'b1);

    // Random phases, each under its own policy and block count. The fixed
    // ones cover every policy code, a single block, no block at all, and
    // counts beyond the table size; the rest are drawn at random.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0:       begin mode = FIT_FIRST; count = 5'd16; end
        1:       begin mode = FIT_BEST;  count = 5'd16; end
        2:       begin mode = FIT_WORST; count = 5'd16; end
        3:       begin mode = FIT_SPARE; count = 5'd16; end
        4:       begin mode = FIT_BEST;  count = 5'd1;  end
        5:       begin mode = FIT_WORST; count = 5'd1;  end
        6:       begin mode = FIT_FIRST; count = 5'd0;  end
        7:       begin mode = FIT_BEST;  count = 5'd31; end
        8:       begin mode = FIT_WORST; count = 5'd17; end
        9:       begin mode = FIT_FIRST; count = 5'd8;  end
        10:      begin mode = FIT_BEST;  count = 5'd5;  end
        11:      begin mode = FIT_WORST; count = 5'd12; end
        default: begin
          mode  = 2'($urandom_range(0, 3));
          count = 5'($urandom_range(1, 16));
        end
      endcase
      if (p >= NUM_PHASES - 2) calm <= 1'b1;
      set_policy(mode, count);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Mostly requests against a table that loads keep refilling. Request
        // sizes are small against typical block sizes so that hits and misses
        // both occur; zero and full-width values show up now and then.
        idx = LOAD_IDX_W'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) begin
          cmd = CMD_LOAD;
          case ($urandom_range(0, 7))
            0:       size = 16'd0;
            1:       size = 16'($urandom_range(0, 65535));
            default: size = 16'($urandom_range(0, 3000));
          endcase
        end else begin
          cmd = CMD_REQUEST;
          case ($urandom_range(0, 15))
            0:       size = 16'd0;
            1, 2:    size = 16'($urandom_range(0, 65535));
            3:       size = 16'hFFFF;
            default: size = 16'($urandom_range(1, 700));
          endcase
        end
        last = ($urandom_range(0, 3) == 0);
        send_item(cmd, idx, size, last);
        // Now and then the sender holds off until every result is back.
        if (k == ITEMS_PER_PHASE / 2 && p % 3 == 0) settle();
        else maybe_gap();
      end
    end

    settle();
    $display("Summary: %0d items sent, %0d of them requests, %0d results checked.",
             items_sent, requests_sent, results_seen);
    $display("Covered all four policy codes, block counts from zero past the table size,",
             " ties, zero and full-width sizes.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit well beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule : tb
